// ===== rtl/i2ccrb_pkg.sv =====
// Shared types, register offsets and bit masks for the I2C controller register bank.
package i2ccrb_pkg;

    // Bus access codes
    typedef enum logic [2:0] {
        OP_RD_HALF = 3'd0,
        OP_WR_HALF = 3'd1,
        OP_RD_BYTE = 3'd2,
        OP_WR_BYTE = 3'd3,
        OP_RD_WORD = 3'd4,
        OP_WR_WORD = 3'd5
    } op_t;

    // Byte offsets that the decoder tests directly
    localparam logic [31:0] OFF_DATA    = 32'h0000_001C;
    localparam logic [31:0] OFF_BUFSTAT = 32'h0000_0040;
    localparam logic [31:0] OFF_LAST    = 32'h0000_0054;

    // Word indexes (offset / 4) of the special registers
    localparam logic [4:0] IDX_STAT = 5'd2;
    localparam logic [4:0] IDX_SYSS = 5'd4;
    localparam logic [4:0] IDX_BUF  = 5'd5;
    localparam logic [4:0] IDX_CNT  = 5'd6;
    localparam logic [4:0] IDX_DATA = 5'd7;
    localparam logic [4:0] IDX_SYSC = 5'd8;
    localparam logic [4:0] IDX_CON  = 5'd9;

    // Number of plain read/write registers
    localparam int PLAIN_CNT = 13;

    // Register bit masks
    localparam logic [15:0] CON_STT   = 16'h0001;
    localparam logic [15:0] CON_TRX   = 16'h0200;
    localparam logic [15:0] SYSC_SRST = 16'h0002;
    localparam logic [15:0] ST_NACK   = 16'h0002;
    localparam logic [15:0] ST_ARDY   = 16'h0004;
    localparam logic [15:0] ST_RRDY   = 16'h0008;
    localparam logic [15:0] ST_TXBITS = 16'h4410;
    localparam logic [15:0] BUF_CLR   = 16'h4040;
    localparam logic [15:0] BUF_XDMA  = 16'h0080;
    localparam logic [15:0] SYSS_DONE = 16'h0001;

    // Decoded access, passed from the decoder to the bank
    typedef struct packed {
        logic       err;
        logic       rd_half;
        logic       wr_half;
        logic       wr_data_byte;
        logic       plain;
        logic [3:0] slot;
        logic [4:0] widx;
    } acc_t;

    // Map a word index onto its plain register slot
    typedef struct packed {
        logic       hit;
        logic [3:0] slot;
    } slot_t;

    function automatic slot_t plain_slot(input logic [4:0] widx);
        slot_t s;
        s.hit  = 1'b1;
        s.slot = 4'd0;
        case (widx)
            5'd1:    s.slot = 4'd0;
            5'd3:    s.slot = 4'd1;
            5'd10:   s.slot = 4'd2;
            5'd11:   s.slot = 4'd3;
            5'd12:   s.slot = 4'd4;
            5'd13:   s.slot = 4'd5;
            5'd14:   s.slot = 4'd6;
            5'd15:   s.slot = 4'd7;
            5'd17:   s.slot = 4'd8;
            5'd18:   s.slot = 4'd9;
            5'd19:   s.slot = 4'd10;
            5'd20:   s.slot = 4'd11;
            5'd21:   s.slot = 4'd12;
            default: s.hit  = 1'b0;
        endcase
        return s;
    endfunction

endpackage

// ===== rtl/i2ccrb_decode.sv =====
// Address and opcode decoder: works out the register offset and rejects bad accesses.
module i2ccrb_decode
    import i2ccrb_pkg::*;
(
    input  logic [2:0]  opcode,
    input  logic [31:0] address,
    input  logic [31:0] base_address,
    output acc_t        acc
);

    logic [31:0] offset;
    logic        known;
    logic        at_data;
    logic        at_bufstat;
    slot_t       ps;

    // Form the offset and the address classes
    assign offset     = address - base_address;
    assign known      = (offset[1:0] == 2'b00) && (offset <= OFF_LAST);
    assign at_data    = (offset == OFF_DATA);
    assign at_bufstat = (offset == OFF_BUFSTAT);
    assign ps         = plain_slot(offset[6:2]);

    // Classify the access
    always_comb
    begin
        acc              = '0;
        acc.widx         = offset[6:2];
        acc.plain        = ps.hit;
        acc.slot         = ps.slot;
        unique case (opcode)
            OP_RD_HALF:
            begin
                acc.rd_half = known;
                acc.err     = !known;
            end
            OP_WR_HALF:
            begin
                acc.wr_half = known;
                acc.err     = !known;
            end
            OP_RD_BYTE:
            begin
                acc.err = !at_data;
            end
            OP_WR_BYTE:
            begin
                acc.wr_data_byte = at_data;
                acc.err          = !at_data;
            end
            OP_RD_WORD:
            begin
                acc.err = !at_bufstat;
            end
            // word writes and undefined codes are always rejected
            default:
            begin
                acc.err = 1'b1;
            end
        endcase
    end

endmodule

// ===== rtl/i2ccrb_bank.sv =====
// Register bank: holds the controller registers, serves reads and applies writes.
module i2ccrb_bank
    import i2ccrb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  acc_t        acc,
    input  logic [15:0] wdata,
    input  logic [6:0]  tx_src,
    output logic [15:0] rdata,
    output logic        fire
);

    logic [15:0] status_reg;
    logic [15:0] status_next;
    logic [15:0] control_reg;
    logic [15:0] control_next;
    logic [15:0] buf_reg;
    logic [15:0] buf_next;
    logic [15:0] count_reg;
    logic [15:0] count_next;
    logic [15:0] sysc_reg;
    logic [15:0] sysc_next;
    logic [15:0] plain_reg [PLAIN_CNT];
    logic [15:0] plain_next [PLAIN_CNT];
    logic        pending_reg;
    logic        pending_next;
    logic        is_read_reg;
    logic        is_read_next;
    logic        dma_ready;

    assign dma_ready = ((buf_reg & BUF_XDMA) != 16'h0000) && (tx_src != 7'd0);

    // Read mux
    always_comb
    begin
        rdata = 16'h0000;
        if (acc.rd_half)
        begin
            if (acc.plain)
            begin
                rdata = plain_reg[acc.slot];
            end
            else
            begin
                unique case (acc.widx)
                    IDX_STAT: rdata = status_reg;
                    IDX_SYSS: rdata = SYSS_DONE;
                    IDX_BUF:  rdata = buf_reg;
                    IDX_CNT:  rdata = count_reg;
                    IDX_SYSC: rdata = sysc_reg;
                    IDX_CON:  rdata = control_reg;
                    default:  rdata = 16'h0000;
                endcase
            end
        end
    end

    // Work out the register updates and the DMA request
    always_comb
    begin
        status_next  = status_reg;
        control_next = control_reg;
        buf_next     = buf_reg;
        count_next   = count_reg;
        sysc_next    = sysc_reg;
        plain_next   = plain_reg;
        pending_next = pending_reg;
        is_read_next = is_read_reg;
        fire         = 1'b0;
        if (acc.wr_data_byte)
        begin
            fire = dma_ready;
        end
        else if (acc.wr_half)
        begin
            if (acc.plain)
            begin
                plain_next[acc.slot] = wdata;
            end
            else
            begin
                unique case (acc.widx)
                    IDX_STAT:
                    begin
                        // close a pending write, then clear the bits written as one
                        if (pending_reg && !is_read_reg && ((wdata & ST_TXBITS) != 16'h0000))
                        begin
                            status_next  = status_reg | ST_NACK | ST_ARDY;
                            pending_next = 1'b0;
                        end
                        status_next = status_next & ~wdata;
                    end
                    IDX_BUF:
                    begin
                        buf_next = wdata & ~BUF_CLR;
                    end
                    IDX_CNT:
                    begin
                        count_next = wdata;
                        if (pending_reg && is_read_reg)
                        begin
                            status_next  = status_reg | ST_NACK | ST_ARDY | ST_RRDY;
                            pending_next = 1'b0;
                        end
                    end
                    IDX_DATA:
                    begin
                        fire = dma_ready;
                    end
                    IDX_SYSC:
                    begin
                        // soft reset clears the bank but for SYSC, which takes the written value without SRST
                        if ((wdata & SYSC_SRST) != 16'h0000)
                        begin
                            status_next  = 16'h0000;
                            control_next = 16'h0000;
                            buf_next     = 16'h0000;
                            count_next   = 16'h0000;
                            pending_next = 1'b0;
                            is_read_next = 1'b0;
                            for (int i = 0; i < PLAIN_CNT; i++)
                            begin
                                plain_next[i] = 16'h0000;
                            end
                        end
                        sysc_next = wdata & ~SYSC_SRST;
                    end
                    IDX_CON:
                    begin
                        control_next = wdata;
                        if ((wdata & CON_STT) != 16'h0000)
                        begin
                            pending_next = 1'b1;
                            is_read_next = ((wdata & CON_TRX) == 16'h0000);
                            control_next = wdata & ~CON_STT;
                            fire         = ((wdata & CON_TRX) != 16'h0000) && dma_ready;
                        end
                    end
                    default:
                    begin
                        // read-only registers ignore writes
                    end
                endcase
            end
        end
    end

    // Hold or advance the bank state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg  <= 16'h0000;
            control_reg <= 16'h0000;
            buf_reg     <= 16'h0000;
            count_reg   <= 16'h0000;
            sysc_reg    <= 16'h0000;
            pending_reg <= 1'b0;
            is_read_reg <= 1'b0;
            for (int i = 0; i < PLAIN_CNT; i++)
            begin
                plain_reg[i] <= 16'h0000;
            end
        end
        else if (en)
        begin
            status_reg  <= status_next;
            control_reg <= control_next;
            buf_reg     <= buf_next;
            count_reg   <= count_next;
            sysc_reg    <= sysc_next;
            pending_reg <= pending_next;
            is_read_reg <= is_read_next;
            plain_reg   <= plain_next;
        end
    end

`ifndef SYNTHESIS
    // A read close always leaves RRDY, NACK and ARDY set
    a_read_close: assert property (@(posedge clk) disable iff (!rst_n)
        en && acc.wr_half && !acc.plain && acc.widx == IDX_CNT && pending_reg && is_read_reg
        |=> !pending_reg && ((status_reg & (ST_NACK | ST_ARDY | ST_RRDY))
            == (ST_NACK | ST_ARDY | ST_RRDY)))
        else $error("read close did not set status bits");

    // The start bit never stays stored in the control word
    a_stt_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (control_reg & CON_STT) == 16'h0000)
        else $error("start bit stored in control word");

    // A DMA request only leaves with DMA enabled and a line configured
    a_fire_ready: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> dma_ready)
        else $error("DMA request without DMA enabled");
`endif

endmodule

// ===== rtl/i2c_controller_register_bank_core.sv =====
// Path: a word is taken into the input register, then into the result register once that
// register is free or its result is being taken; out_stall can hold it between the two.
// Throughput: one word per cycle unless out_stall holds the result; decode and bank update fit
// between the input register and the result register, so accesses follow back to back.
// Reset: rst_n clears the bank, both configuration registers and all valid flags
// at once; a SYSC soft reset clears the bank alone, in the cycle the write is applied.
// Top level of the I2C controller register bank: input register, decode, bank, result register.
module i2c_controller_register_bank_core
    import i2ccrb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  opcode,
    input  logic [31:0] address,
    input  logic [15:0] write_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] read_data,
    output logic        tx_dma_fire,
    output logic [6:0]  tx_dma_line,
    output logic        access_error
);

    logic [31:0] base_reg;
    logic [6:0]  tx_src_reg;
    logic        in_valid_reg;
    logic [2:0]  op_reg;
    logic [31:0] addr_reg;
    logic [15:0] data_reg;
    logic        out_valid_reg;
    logic [15:0] rdata_reg;
    logic        fire_reg;
    logic [6:0]  line_reg;
    logic        err_reg;
    logic        advance;
    acc_t        acc;
    logic [15:0] rdata;
    logic        fire;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= 32'h0000_0000;
            tx_src_reg <= 7'd0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == 1'b0)
            begin
                base_reg <= cfg_data;
            end
            else
            begin
                tx_src_reg <= cfg_data[6:0];
            end
        end
    end

    // Move the held word on when the result register is free
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            op_reg   <= opcode;
            addr_reg <= address;
            data_reg <= write_data;
        end
    end

    i2ccrb_decode u_decode (
        .opcode       (op_reg),
        .address      (addr_reg),
        .base_address (base_reg),
        .acc          (acc)
    );

    i2ccrb_bank u_bank (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (advance),
        .acc    (acc),
        .wdata  (data_reg),
        .tx_src (tx_src_reg),
        .rdata  (rdata),
        .fire   (fire)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rdata_reg <= rdata;
            fire_reg  <= fire;
            line_reg  <= fire ? tx_src_reg : 7'd0;
            err_reg   <= acc.err;
        end
    end

    assign out_valid    = out_valid_reg;
    assign read_data    = rdata_reg;
    assign tx_dma_fire  = fire_reg;
    assign tx_dma_line  = line_reg;
    assign access_error = err_reg;

`ifndef SYNTHESIS
    // A raised DMA request always names a wired line
    a_line_set: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && tx_dma_fire |-> tx_dma_line != 7'd0)
        else $error("DMA request with no line");

    // A rejected access returns nothing else
    a_err_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && access_error |-> read_data == 16'h0000 && !tx_dma_fire)
        else $error("rejected access returned data");

    // A word moved on from the input register shows as a result next cycle
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid)
        else $error("advanced word lost");
`endif

endmodule
